FILE: hw/rtl/mie_pkg.sv
// package for the modular inverse block
// holds the sequencer state type and its codes; no dependencies
package mie_pkg;

  typedef logic [2:0] state_t;

  localparam state_t ST_IDLE = 3'd0;
  localparam state_t ST_CHK  = 3'd1;
  localparam state_t ST_DIV  = 3'd2;
  localparam state_t ST_FIN  = 3'd3;

endpackage

FILE: hw/rtl/modular_inverse_euclid.sv
// Modular inverse of value modulo modulus by the extended Euclidean algorithm.
// Each input transfer carries value and modulus; each produces one output
// transfer with the inverse in 0..modulus-1 and a tuser flag that is set when
// gcd(value, modulus) is 1 (inverse is zero when the flag is clear, and for a
// zero modulus). One shared unit runs a restoring division one quotient bit a
// cycle and, in the cycle after, folds that bit into the Bezout coefficient by
// modular double-and-add. A new item is taken while the previous result waits.
// depends on mie_pkg
module modular_inverse_euclid
  import mie_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((2 * WIDTH + 7) / 8) * 8-1:0] s_tdata,   // value, modulus, zero pad
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((WIDTH + 7) / 8) * 8-1:0]     m_tdata,   // inverse, zero pad
  output logic                                 m_tuser    // valid_res
);

  localparam int OUT_W = ((WIDTH + 7) / 8) * 8;
  localparam int CNT_W = $clog2(WIDTH + 1);

  state_t             state;
  logic [WIDTH-1:0]   m;
  logic [WIDTH-1:0]   r_prev;
  logic [WIDTH-1:0]   r_cur;
  logic [WIDTH-1:0]   c_prev;
  logic [WIDTH-1:0]   c_cur;
  logic [WIDTH-1:0]   dvd;
  logic [WIDTH-1:0]   rem;
  logic [WIDTH-1:0]   acc;
  logic               qb;
  logic [CNT_W-1:0]   cnt;
  logic [WIDTH-1:0]   inverse;
  logic               valid_res;

  logic [WIDTH-1:0]   in_value;
  logic [WIDTH-1:0]   in_modulus;
  logic [WIDTH:0]     trial;
  logic [WIDTH:0]     diff;
  logic               div_bit;
  logic [WIDTH+1:0]   sum;
  logic [WIDTH+1:0]   sum_m1;
  logic [WIDTH+1:0]   sum_m2;
  logic [WIDTH-1:0]   acc_next;
  logic [WIDTH:0]     sub_raw;
  logic [WIDTH-1:0]   c_next;
  logic               out_free;

  assign in_value   = s_tdata[WIDTH-1:0];
  assign in_modulus = s_tdata[2*WIDTH-1:WIDTH];
  assign s_tready   = (state == ST_IDLE);
  assign out_free   = !m_tvalid || m_tready;

  // division step
  assign trial   = {rem, dvd[WIDTH-1]};
  assign diff    = trial - {1'b0, r_cur};
  assign div_bit = !diff[WIDTH];

  // modular horner step on the previous quotient bit
  always_comb begin
    sum    = {1'b0, acc, 1'b0} + (qb ? {2'b00, c_cur} : '0);
    sum_m1 = sum - {2'b00, m};
    sum_m2 = sum - {1'b0, m, 1'b0};
    if (!sum_m2[WIDTH+1]) begin
      acc_next = sum_m2[WIDTH-1:0];
    end else if (!sum_m1[WIDTH+1]) begin
      acc_next = sum_m1[WIDTH-1:0];
    end else begin
      acc_next = sum[WIDTH-1:0];
    end
  end

  // c_prev - q*c_cur mod m
  always_comb begin
    sub_raw = {1'b0, c_prev} - {1'b0, acc};
    if (sub_raw[WIDTH]) begin
      c_next = sub_raw[WIDTH-1:0] + m;
    end else begin
      c_next = sub_raw[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !(state == ST_CHK && r_cur == '0)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            m      <= in_modulus;
            r_prev <= in_modulus;
            r_cur  <= (in_modulus == '0) ? '0 : in_value;
            c_prev <= '0;
            c_cur  <= (in_modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
            state  <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (r_cur != '0) begin
            dvd   <= r_prev;
            rem   <= '0;
            acc   <= '0;
            qb    <= 1'b0;
            cnt   <= '0;
            state <= ST_DIV;
          end else if (out_free) begin
            m_tvalid  <= 1'b1;
            valid_res <= (r_prev == WIDTH'(1));
            inverse   <= (r_prev == WIDTH'(1)) ? c_prev : '0;
            state     <= ST_IDLE;
          end
        end
        ST_DIV: begin
          acc <= acc_next;
          if (cnt == CNT_W'(WIDTH)) begin
            state <= ST_FIN;
          end else begin
            dvd <= {dvd[WIDTH-2:0], 1'b0};
            rem <= div_bit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            qb  <= div_bit;
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_FIN: begin
          r_prev <= r_cur;
          r_cur  <= rem;
          c_prev <= c_cur;
          c_cur  <= c_next;
          state  <= ST_CHK;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = OUT_W'(inverse);
  assign m_tuser = valid_res;

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> r_cur != '0)
    else $error("division by zero remainder");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < r_cur)
    else $error("partial remainder not below divisor");

  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> acc < m)
    else $error("coefficient accumulator not reduced");

  a_coef_reduced: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHK && m != '0 |-> c_cur < m && c_prev < m)
    else $error("bezout coefficient out of range");

endmodule
